// ===== hw/rtl/swtsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Square wave tone sweep generator package
// Widths, operation codes, controller states and shared structures.
// ----------------------------------------------------------------------------
package swtsg_pkg;

   localparam int PHASE_BITS       = 32;
   localparam int DIVISOR_BITS     = 16;
   localparam int SPT_BITS         = 12;
   localparam int CLOCK_RATIO_BITS = 26;
   localparam int AMPLITUDE_BITS   = 15;
   localparam int START_DIV_BITS   = 16;
   localparam int DELTA_BITS       = 16;
   localparam int TICK_BITS        = 8;
   localparam int SAMPLE_BITS      = 16;
   localparam int CSR_ADDR_BITS    = 4;
   localparam int CSR_DATA_BITS    = 32;

   localparam int DIVIDEND_BITS  = CLOCK_RATIO_BITS + PHASE_BITS - 16;
   localparam int DIV_COUNT_BITS = $clog2(DIVIDEND_BITS + 1);
   localparam int SUM_BITS       = ((DIVISOR_BITS > DELTA_BITS) ? DIVISOR_BITS : DELTA_BITS) + 2;

   localparam logic [SPT_BITS-1:0]         SPT_RESET         = SPT_BITS'(630);
   localparam logic [CLOCK_RATIO_BITS-1:0] CLOCK_RATIO_RESET = CLOCK_RATIO_BITS'(1773161);
   localparam logic [AMPLITUDE_BITS-1:0]   AMPLITUDE_RESET   = AMPLITUDE_BITS'(8000);

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_STROBE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_TICK_SAMPLES = 2'd0,
      REG_CLOCK_RATIO  = 2'd1,
      REG_AMPLITUDE    = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [SPT_BITS-1:0]         tick_samples;
      logic [CLOCK_RATIO_BITS-1:0] clock_ratio;
      logic [AMPLITUDE_BITS-1:0]   amplitude;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic start_tick;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic tick_needed;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ===== hw/rtl/swtsg_channels.sv =====
// ----------------------------------------------------------------------------
// Square wave tone sweep generator channels
// Request and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface swtsg_req_if import swtsg_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic                           operation;
   logic [START_DIV_BITS-1:0]      start_divisor;
   logic signed [DELTA_BITS-1:0]   delta;
   logic [TICK_BITS-1:0]           tick_count;
   logic                           final_segment;

   modport source(output valid, output operation, output start_divisor, output delta,
                  output tick_count, output final_segment, input ready);
   modport sink(input valid, input operation, input start_divisor, input delta,
                input tick_count, input final_segment, output ready);
endinterface

interface swtsg_rsp_if import swtsg_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          active;
   logic                          segment_done;
   logic                          sound_done;

   modport source(output valid, output sample, output active, output segment_done,
                  output sound_done, input ready);
   modport sink(input valid, input sample, input active, input segment_done,
                input sound_done, output ready);
endinterface

// ===== hw/rtl/square_wave_tone_sweep_generator.sv =====
// ----------------------------------------------------------------------------
// Square wave tone sweep generator
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// The request channel carries segment loads and sample strobes; a load
// returns nothing. Every strobe returns exactly one result on the response
// channel: a square wave sample of plus or minus the amplitude, or silence
// when no segment is running. A strobe is accepted in the idle state; the
// emit state then registers its result once the output register is free.
// A strobe that starts a sweep tick first runs the serial step divider, one
// quotient bit per cycle. No request is taken until the pending strobe is
// emitted; after a load the block stays idle. The configuration port is
// APB style with registers tick_samples, clock_ratio and amplitude at byte
// addresses 0, 4 and 8; write them only while the block is idle.
// Reset is synchronous and restores the configuration, controller and sweep
// state; the divider and result data registers are not reset.
// If the receiver stalls, the result is held in the output register; the next
// request is still accepted, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module square_wave_tone_sweep_generator import swtsg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   swtsg_req_if.sink                req_ch,
   swtsg_rsp_if.source              rsp_ch,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [SPT_BITS-1:0]         spt_ff, spt_in;
   logic [CLOCK_RATIO_BITS-1:0] ratio_ff, ratio_in;
   logic [AMPLITUDE_BITS-1:0]   amp_ff, amp_in;
   logic                        csr_write;
   reg_index_type               csr_index;
   cfg_type                     cfg;
   cmd_type                     cmd;
   status_type                  status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      spt_in   = spt_ff;
      ratio_in = ratio_ff;
      amp_in   = amp_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_TICK_SAMPLES: spt_in   = csr_pwdata[SPT_BITS-1:0];
            REG_CLOCK_RATIO:  ratio_in = csr_pwdata[CLOCK_RATIO_BITS-1:0];
            REG_AMPLITUDE:    amp_in   = csr_pwdata[AMPLITUDE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_TICK_SAMPLES: csr_prdata = CSR_DATA_BITS'(spt_ff);
         REG_CLOCK_RATIO:  csr_prdata = CSR_DATA_BITS'(ratio_ff);
         REG_AMPLITUDE:    csr_prdata = CSR_DATA_BITS'(amp_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff   <= SPT_RESET;
         ratio_ff <= CLOCK_RATIO_RESET;
         amp_ff   <= AMPLITUDE_RESET;
      end else begin
         spt_ff   <= spt_in;
         ratio_ff <= ratio_in;
         amp_ff   <= amp_in;
      end
   end

   assign cfg.tick_samples = spt_ff;
   assign cfg.clock_ratio  = ratio_ff;
   assign cfg.amplitude    = amp_ff;

   swtsg_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ch.ready),
      .status        (status),
      .cmd           (cmd)
   );

   swtsg_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_start_divisor (req_ch.start_divisor),
      .req_delta         (req_ch.delta),
      .req_tick_count    (req_ch.tick_count),
      .req_final_segment (req_ch.final_segment),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_sample        (rsp_ch.sample),
      .rsp_active        (rsp_ch.active),
      .rsp_segment_done  (rsp_ch.segment_done),
      .rsp_sound_done    (rsp_ch.sound_done)
   );

endmodule

// ===== hw/rtl/swtsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// Square wave tone sweep generator controller
// Sequences request acceptance, the step division and result emission.
// ----------------------------------------------------------------------------
module swtsg_ctrl import swtsg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_operation,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept) begin
               if (req_operation == OP_LOAD) begin
                  cmd.load = 1'b1;
               end else if (status.tick_needed) begin
                  cmd.start_tick = 1'b1;
                  state_in       = ST_DIVIDE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.start_tick, cmd.div_step, cmd.emit}))
      else $error("controller issued more than one command");

   a_divide_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && status.div_done) |=> (state_ff == ST_EMIT))
      else $error("finished division did not lead to emission");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("emission into an occupied result register");
`endif

endmodule

// ===== hw/rtl/swtsg_dp.sv =====
// ----------------------------------------------------------------------------
// Square wave tone sweep generator datapath
// Sweep state, serial step divider, phase accumulator and result register.
// ----------------------------------------------------------------------------
module swtsg_dp import swtsg_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  logic [START_DIV_BITS-1:0]     req_start_divisor,
   input  logic signed [DELTA_BITS-1:0]  req_delta,
   input  logic [TICK_BITS-1:0]          req_tick_count,
   input  logic                          req_final_segment,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_active,
   output logic                          rsp_segment_done,
   output logic                          rsp_sound_done
);

   logic [DIVISOR_BITS-1:0]       divisor_ff, divisor_in;
   logic signed [DELTA_BITS-1:0]  delta_ff, delta_in;
   logic [TICK_BITS-1:0]          ticks_ff, ticks_in;
   logic [SPT_BITS-1:0]           samples_left_ff, samples_left_in;
   logic [PHASE_BITS-1:0]         phase_ff, phase_in;
   logic [PHASE_BITS-1:0]         step_ff, step_in;
   logic                          final_ff, final_in;
   logic [DIV_COUNT_BITS-1:0]     count_ff, count_in;
   logic [DIVIDEND_BITS-1:0]      quot_ff, quot_in;
   logic [DIVISOR_BITS-1:0]       rem_ff, rem_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                          active_ff, active_in;
   logic                          seg_done_ff, seg_done_in;
   logic                          snd_done_ff, snd_done_in;

   logic [DIVISOR_BITS-1:0]       load_divisor;
   logic signed [SUM_BITS-1:0]    sum;
   logic [DIVISOR_BITS-1:0]       sat_divisor;
   logic [DIVISOR_BITS:0]         partial;
   logic                          fits;
   logic [DIVISOR_BITS:0]         partial_diff;
   logic [PHASE_BITS-1:0]         phase_next;
   logic [SAMPLE_BITS-1:0]        magnitude;
   logic [SPT_BITS-1:0]           samples_after;
   logic                          seg_end;

   assign status.tick_needed = (samples_left_ff == '0) && (ticks_ff != '0);
   assign status.div_done    = (count_ff == DIV_COUNT_BITS'(1));
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign load_divisor = DIVISOR_BITS'(req_start_divisor);
   assign sum          = $signed(SUM_BITS'(divisor_ff)) + SUM_BITS'(delta_ff);

   always_comb begin
      if (sum[SUM_BITS-1] || sum == '0) begin
         sat_divisor = DIVISOR_BITS'(1);
      end else if (sum[SUM_BITS-2:DIVISOR_BITS] != '0) begin
         sat_divisor = '1;
      end else begin
         sat_divisor = sum[DIVISOR_BITS-1:0];
      end
   end

   assign partial      = {rem_ff, quot_ff[DIVIDEND_BITS-1]};
   assign fits         = partial >= {1'b0, divisor_ff};
   assign partial_diff = partial - {1'b0, divisor_ff};

   assign phase_next    = phase_ff + step_ff;
   assign magnitude     = {1'b0, cfg.amplitude};
   assign samples_after = samples_left_ff - SPT_BITS'(1);
   assign seg_end       = (samples_after == '0) && (ticks_ff == '0);

   always_comb begin
      divisor_in      = divisor_ff;
      delta_in        = delta_ff;
      ticks_in        = ticks_ff;
      samples_left_in = samples_left_ff;
      phase_in        = phase_ff;
      step_in         = step_ff;
      final_in        = final_ff;
      count_in        = count_ff;
      quot_in         = quot_ff;
      rem_in          = rem_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      sample_in       = sample_ff;
      active_in       = active_ff;
      seg_done_in     = seg_done_ff;
      snd_done_in     = snd_done_ff;

      if (cmd.load) begin
         if (load_divisor != '0) begin
            divisor_in = load_divisor;
         end
         delta_in        = req_delta;
         ticks_in        = req_tick_count;
         samples_left_in = '0;
         final_in        = req_final_segment;
      end

      if (cmd.start_tick) begin
         divisor_in      = sat_divisor;
         ticks_in        = ticks_ff - TICK_BITS'(1);
         samples_left_in = (cfg.tick_samples == '0) ? SPT_BITS'(1) : cfg.tick_samples;
         count_in        = DIV_COUNT_BITS'(DIVIDEND_BITS);
         quot_in         = DIVIDEND_BITS'(cfg.clock_ratio) << (PHASE_BITS - 16);
         rem_in          = '0;
      end

      if (cmd.div_step) begin
         count_in = count_ff - DIV_COUNT_BITS'(1);
         quot_in  = {quot_ff[DIVIDEND_BITS-2:0], fits};
         rem_in   = fits ? partial_diff[DIVISOR_BITS-1:0] : partial[DIVISOR_BITS-1:0];
         if (status.div_done) begin
            step_in = quot_in[PHASE_BITS-1:0];
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (samples_left_ff == '0) begin
            sample_in   = '0;
            active_in   = 1'b0;
            seg_done_in = 1'b0;
            snd_done_in = 1'b0;
         end else begin
            sample_in       = phase_next[PHASE_BITS-1] ? -$signed(magnitude) : $signed(magnitude);
            active_in       = 1'b1;
            seg_done_in     = seg_end;
            snd_done_in     = seg_end && final_ff;
            samples_left_in = samples_after;
            if (seg_end && final_ff) begin
               phase_in = '0;
               final_in = 1'b0;
            end else begin
               phase_in = phase_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff      <= DIVISOR_BITS'(1);
         delta_ff        <= '0;
         ticks_ff        <= '0;
         samples_left_ff <= '0;
         phase_ff        <= '0;
         step_ff         <= '0;
         final_ff        <= 1'b0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         divisor_ff      <= divisor_in;
         delta_ff        <= delta_in;
         ticks_ff        <= ticks_in;
         samples_left_ff <= samples_left_in;
         phase_ff        <= phase_in;
         step_ff         <= step_in;
         final_ff        <= final_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      sample_ff   <= sample_in;
      active_ff   <= active_in;
      seg_done_ff <= seg_done_in;
      snd_done_ff <= snd_done_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample       = sample_ff;
   assign rsp_active       = active_ff;
   assign rsp_segment_done = seg_done_ff;
   assign rsp_sound_done   = snd_done_ff;

`ifndef SYNTHESIS
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      divisor_ff != '0)
      else $error("timer divisor reached zero");

   a_sound_implies_segment: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && snd_done_ff) |-> (seg_done_ff && active_ff))
      else $error("sound end flagged without segment end");

   a_sound_end_phase: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && samples_left_ff != '0 && seg_end && final_ff) |=>
      (phase_ff == '0 && !final_ff))
      else $error("phase not cleared at end of sound");
`endif

endmodule

// ===== tb/tb_square_wave_tone_sweep_generator.sv =====
// ----------------------------------------------------------------------------
// Square wave tone sweep generator testbench
// Sends segment loads and sample strobes to the generator under several
// register settings. A directed table covers the extremes and corner cases,
// then random load and strobe sequences follow. Results are checked against
// fixed directed values or an in-bench model of the sweep, phase accumulator
// and done flags, while requests idle and responses stall at random.
// ----------------------------------------------------------------------------
module tb_square_wave_tone_sweep_generator import swtsg_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASE_ITEMS  = 160;
   localparam int NUM_PHASES   = 10;
   localparam logic [CLOCK_RATIO_BITS-1:0] CLOCK_RATIO_MAX = '1;
   localparam logic [AMPLITUDE_BITS-1:0]   AMPLITUDE_MAX   = '1;

   typedef struct packed {
      op_type                       op;
      logic [START_DIV_BITS-1:0]    start_divisor;
      logic signed [DELTA_BITS-1:0] delta;
      logic [TICK_BITS-1:0]         tick_count;
      logic                         final_segment;
   } tone_request_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          active;
      logic                          segment_done;
      logic                          sound_done;
   } tone_sample_type;

   typedef struct packed {
      tone_request_type req;
      logic             typed;
      tone_sample_type  want;
   } directed_row_type;

   localparam tone_sample_type SILENCE = '0;

   // Run with two samples per tick and the largest clock ratio and amplitude.
   localparam directed_row_type DIRECTED [22] = '{
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b1, SILENCE},
      '{'{OP_LOAD,   16'd0,     16'h0000, 8'd0,   1'b1}, 1'b0, SILENCE},
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b1, SILENCE},
      '{'{OP_LOAD,   16'd65535, 16'h7FFF, 8'd2,   1'b1}, 1'b0, SILENCE},
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b0, SILENCE},
      '{'{OP_STROBE, 16'hFFFF,  16'hFFFF, 8'hFF,  1'b1}, 1'b0, SILENCE},
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b0, SILENCE},
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b0, SILENCE},
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b1, SILENCE},
      '{'{OP_LOAD,   16'd1,     16'h8000, 8'd3,   1'b0}, 1'b0, SILENCE},
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b0, SILENCE},
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b0, SILENCE},
      '{'{OP_LOAD,   16'd300,   16'hFFFB, 8'd1,   1'b1}, 1'b0, SILENCE},
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b0, SILENCE},
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b0, SILENCE},
      '{'{OP_LOAD,   16'd0,     16'h0064, 8'd255, 1'b0}, 1'b0, SILENCE},
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b0, SILENCE},
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b0, SILENCE},
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b0, SILENCE},
      '{'{OP_LOAD,   16'd0,     16'h0000, 8'd0,   1'b0}, 1'b0, SILENCE},
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b1, SILENCE},
      '{'{OP_STROBE, 16'd0,     16'h0000, 8'd0,   1'b0}, 1'b1, SILENCE}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   swtsg_req_if req_ch();
   swtsg_rsp_if rsp_ch();

   square_wave_tone_sweep_generator uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [SPT_BITS-1:0]         cfg_spt         = SPT_RESET;
   logic [CLOCK_RATIO_BITS-1:0] cfg_clock_ratio = CLOCK_RATIO_RESET;
   logic [AMPLITUDE_BITS-1:0]   cfg_amplitude   = AMPLITUDE_RESET;

   logic [DIVISOR_BITS-1:0]      cur_div           = DIVISOR_BITS'(1);
   logic signed [DELTA_BITS-1:0] sweep_delta       = '0;
   logic [TICK_BITS-1:0]         ticks_left        = '0;
   logic [SPT_BITS-1:0]          tick_samples_left = '0;
   logic [PHASE_BITS-1:0]        phase_acc         = '0;
   logic [PHASE_BITS-1:0]        phase_inc         = '0;
   logic                         sound_final       = 1'b0;

   tone_sample_type expected_samples[$];
   int error_count  = 0;
   int result_index = 0;
   int items_sent   = 0;
   int burst_left   = 1;
   int stall_window = 0;
   int stall_mode   = 0;

   always #5 clock = ~clock;

   task automatic report_mismatch(string what);
      $display("result %0d: %s", result_index, what);
      error_count++;
   endtask

   task automatic predict_tone(input tone_request_type r, output bit has_result,
                               output tone_sample_type res);
      int                            sum;
      longint unsigned               scaled;
      logic signed [SAMPLE_BITS-1:0] mag;
      has_result = 1'b0;
      res = SILENCE;
      if (r.op == OP_LOAD) begin
         if (r.start_divisor != 0) cur_div = r.start_divisor;
         sweep_delta = r.delta;
         ticks_left = r.tick_count;
         tick_samples_left = '0;
         sound_final = r.final_segment;
      end else begin
         has_result = 1'b1;
         if (tick_samples_left == 0 && ticks_left != 0) begin
            sum = int'(cur_div) + int'(sweep_delta);
            if (sum < 1) sum = 1;
            else if (sum > 65535) sum = 65535;
            cur_div = DIVISOR_BITS'(sum);
            scaled = longint'(cfg_clock_ratio) << 16;
            phase_inc = PHASE_BITS'(scaled / cur_div);
            ticks_left = ticks_left - 8'd1;
            tick_samples_left = (cfg_spt == 0) ? SPT_BITS'(1) : cfg_spt;
         end
         if (tick_samples_left != 0) begin
            phase_acc = phase_acc + phase_inc;
            mag = {1'b0, cfg_amplitude};
            res.sample = phase_acc[PHASE_BITS-1] ? -mag : mag;
            res.active = 1'b1;
            tick_samples_left = tick_samples_left - 1'b1;
            res.segment_done = (tick_samples_left == 0) && (ticks_left == 0);
            res.sound_done = res.segment_done && sound_final;
            if (res.sound_done) begin
               phase_acc = '0;
               sound_final = 1'b0;
            end
         end
      end
   endtask

   task automatic send_request(tone_request_type r, bit typed, tone_sample_type want);
      bit              has_result;
      tone_sample_type predicted;
      req_ch.valid <= 1'b1;
      req_ch.operation <= r.op;
      req_ch.start_divisor <= r.start_divisor;
      req_ch.delta <= r.delta;
      req_ch.tick_count <= r.tick_count;
      req_ch.final_segment <= r.final_segment;
      do @(posedge clock); while (!req_ch.ready);
      predict_tone(r, has_result, predicted);
      if (has_result) expected_samples.push_back(typed ? want : predicted);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_samples.size() != 0);
   endtask

   task automatic write_register(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_TICK_SAMPLES: cfg_spt = value[SPT_BITS-1:0];
         REG_CLOCK_RATIO:  cfg_clock_ratio = value[CLOCK_RATIO_BITS-1:0];
         default:          cfg_amplitude = value[AMPLITUDE_BITS-1:0];
      endcase
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(int spt, int ratio, int amp);
      write_register(REG_TICK_SAMPLES, CSR_DATA_BITS'(spt));
      write_register(REG_CLOCK_RATIO, CSR_DATA_BITS'(ratio));
      write_register(REG_AMPLITUDE, CSR_DATA_BITS'(amp));
   endtask

   function automatic tone_request_type random_load(int spt_eff);
      tone_request_type r;
      r.op = OP_LOAD;
      case ($urandom_range(0, 7))
         0:       r.start_divisor = '0;
         1:       r.start_divisor = '1;
         2:       r.start_divisor = 16'd1;
         3:       r.start_divisor = 16'($urandom_range(0, 65535));
         default: r.start_divisor = 16'($urandom_range(20, 3000));
      endcase
      case ($urandom_range(0, 7))
         0:       r.delta = 16'h8000;
         1:       r.delta = 16'h7FFF;
         2:       r.delta = 16'($urandom_range(0, 65535));
         default: r.delta = 16'($urandom_range(0, 80)) - 16'd40;
      endcase
      if ($urandom_range(0, 9) == 0) r.tick_count = 8'($urandom_range(0, 255));
      else if (spt_eff > 16) r.tick_count = 8'd1;
      else r.tick_count = 8'($urandom_range(1, 4));
      r.final_segment = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic run_random(int budget);
      int               target;
      int               kind;
      int               n;
      int               spt_eff;
      tone_request_type r;
      target = items_sent + budget;
      while (items_sent < target) begin
         kind = $urandom_range(0, 19);
         spt_eff = (cfg_spt == 0) ? 1 : int'(cfg_spt);
         if (kind == 0) begin
            hold_until_drained();
         end else if (kind < 15) begin
            r = random_load(spt_eff);
            send_request(r, 1'b0, SILENCE);
            n = int'(r.tick_count) * spt_eff + $urandom_range(0, 2);
            if (kind >= 12) n = $urandom_range(0, n);
            if (n > 48) n = 48;
            repeat (n) begin
               r = random_load(spt_eff);
               r.op = OP_STROBE;
               send_request(r, 1'b0, SILENCE);
            end
         end else if (kind < 18) begin
            r = random_load(spt_eff);
            r.tick_count = 8'($urandom_range(0, 255));
            send_request(r, 1'b0, SILENCE);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               r = random_load(spt_eff);
               r.op = OP_STROBE;
               send_request(r, 1'b0, SILENCE);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_window == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_window = $urandom_range(32, 160);
      end else begin
         stall_window--;
      end
      case (stall_mode)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
         2:       rsp_ch.ready <= (stall_window % 3) != 0;
         default: rsp_ch.ready <= (stall_window % 16) < 4;
      endcase
   end

   always @(posedge clock) begin
      tone_sample_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected sample %0d", rsp_ch.sample));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_ch.sample !== want.sample)
               report_mismatch($sformatf("sample %0d, expected %0d",
                                         rsp_ch.sample, want.sample));
            if (rsp_ch.active !== want.active)
               report_mismatch($sformatf("active %b, expected %b",
                                         rsp_ch.active, want.active));
            if (rsp_ch.segment_done !== want.segment_done)
               report_mismatch($sformatf("segment_done %b, expected %b",
                                         rsp_ch.segment_done, want.segment_done));
            if (rsp_ch.sound_done !== want.sound_done)
               report_mismatch($sformatf("sound_done %b, expected %b",
                                         rsp_ch.sound_done, want.sound_done));
         end
         result_index++;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.operation = OP_LOAD;
      req_ch.start_divisor = '0;
      req_ch.delta = '0;
      req_ch.tick_count = '0;
      req_ch.final_segment = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_config(2, int'(CLOCK_RATIO_MAX), int'(AMPLITUDE_MAX));
      foreach (DIRECTED[i]) send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);

      for (int p = 0; p < NUM_PHASES; p++) begin
         hold_until_drained();
         repeat (DRAIN_CYCLES) @(posedge clock);
         case (p)
            0:       set_config(1, 1, 0);
            1:       set_config(4095, int'(CLOCK_RATIO_MAX), int'(AMPLITUDE_MAX));
            2:       set_config(0, $urandom_range(1, 67108863), $urandom_range(0, 32767));
            3:       set_config(int'(SPT_RESET), int'(CLOCK_RATIO_RESET),
                                int'(AMPLITUDE_RESET));
            default: set_config($urandom_range(1, 6), $urandom_range(1, 67108863),
                                $urandom_range(0, 32767));
         endcase
         run_random(PHASE_ITEMS);
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
